// ===== rtl/core/ascii_integer_parser_defines.svh =====
// ---------------------------------------------------------------------------
// ascii_integer_parser_defines: assertion macros
// Shared property shorthands for the parser's checker.
// ---------------------------------------------------------------------------
`ifndef ASCII_INTEGER_PARSER_DEFINES_SVH
`define ASCII_INTEGER_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on the rising edge, held off during reset.
`define AIP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising edge, held off during reset.
`define AIP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/aip_pkg.sv =====
// ---------------------------------------------------------------------------
// aip_pkg: ASCII integer parser package
// Types, widths, character codes and the digit decoder of the parser.
// ---------------------------------------------------------------------------
`default_nettype none

package aip_pkg;

  // Parameter defaults
  localparam int unsigned CHAR_BITS_DEF   = 16;
  localparam int unsigned OFFSET_BITS_DEF = 16;

  // Field widths
  localparam int unsigned CHAR_W      = 16;
  localparam int unsigned BASE_W      = 6;
  localparam int unsigned VALUE_W     = 64;
  localparam int unsigned OFFSET_W    = 16;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 88;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_TAB     = 16'h0009;
  localparam logic [CHAR_W-1:0] CH_CR      = 16'h000d;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 16'h0020;
  localparam logic [CHAR_W-1:0] CH_PLUS    = 16'h002b;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 16'h002d;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 16'h0030;
  localparam logic [CHAR_W-1:0] CH_NINE    = 16'h0039;
  localparam logic [CHAR_W-1:0] CH_A_UP    = 16'h0041;
  localparam logic [CHAR_W-1:0] CH_Z_UP    = 16'h005a;
  localparam logic [CHAR_W-1:0] CH_A_LO    = 16'h0061;
  localparam logic [CHAR_W-1:0] CH_Z_LO    = 16'h007a;
  localparam logic [CHAR_W-1:0] CH_X_UP    = 16'h0058;
  localparam logic [CHAR_W-1:0] CH_X_LO    = 16'h0078;
  localparam logic [CHAR_W-1:0] ASCII_MAX  = 16'h007f;

  // Bases
  localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
  localparam logic [BASE_W-1:0] BASE_ONE  = 6'd1;
  localparam logic [BASE_W-1:0] BASE_MIN  = 6'd2;
  localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;
  localparam logic [BASE_W-1:0] BASE_MAX  = 6'd36;
  localparam logic [BASE_W-1:0] NOT_DIGIT = 6'd36;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_BLANKS,
    PH_SIGNED,
    PH_ZERO,
    PH_DIGITS,
    PH_DONE
  } phase_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NODIGITS = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_BADBASE  = 2'd3
  } status_e;

  // Digit value 0..35, or NOT_DIGIT
  function automatic logic [BASE_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [BASE_W-1:0] d;
    d = NOT_DIGIT;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = BASE_W'(c - CH_ZERO);
    end else if (c >= CH_A_UP && c <= CH_Z_UP) begin
      d = BASE_W'(c - CH_A_UP) + BASE_DEC;
    end else if (c >= CH_A_LO && c <= CH_Z_LO) begin
      d = BASE_W'(c - CH_A_LO) + BASE_DEC;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ascii_integer_parser.sv =====
// ---------------------------------------------------------------------------
// ascii_integer_parser: streaming text to unsigned 64-bit integer converter
// Takes one character per transaction and emits at most one value per string.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                  Payload
//  s_axis    in         s_axis_tvalid/tready       char_code (tdata), first_char (tuser)
//  m_axis    out        m_axis_tvalid/tready       parsed_value, end_offset, parse_status
//  cfg       in         cfg_we_i (no back-pressure) number_base
//
//  One character per clock cycle, sustained while the result stream does not stall; the
//  only feedback loop is the parse state, updated by a combinational 64x6 multiply-add.
//  A character is registered in the input register, then processed; its result (if any)
//  is loaded into the result register at the edge where it is processed, and that register
//  drives m_axis_tvalid.
//  Reset returns the parser to idle with the base register cleared to auto.
//  A stalled result holds processing; the input register then fills and
//  s_axis_tready drops.
// ---------------------------------------------------------------------------
`default_nettype none

module ascii_integer_parser #(
  parameter int unsigned CHAR_BITS   = aip_pkg::CHAR_BITS_DEF,
  parameter int unsigned OFFSET_BITS = aip_pkg::OFFSET_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Configuration: number_base
  input  wire logic                             cfg_we_i,
  input  wire logic [aip_pkg::BASE_W-1:0]       cfg_wdata_i,
  // Input stream
  input  wire logic                             s_axis_tvalid,
  output      logic                             s_axis_tready,
  input  wire logic [aip_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [15:0] char_code
  input  wire logic                             s_axis_tuser,  // [0] first_char
  // Result stream
  output      logic                             m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output      logic [aip_pkg::OUT_TDATA_W-1:0]  m_axis_tdata   // [63:0] parsed_value,
                                                              // [79:64] end_offset,
                                                              // [81:80] parse_status,
                                                              // [87:82] zero
);

  // Offset counter width: saturates at min(2^OFFSET_BITS-1, 65535)
  localparam int unsigned POS_W  = (OFFSET_BITS < aip_pkg::OFFSET_W) ? OFFSET_BITS
                                                                     : aip_pkg::OFFSET_W;
  localparam int unsigned PROD_W = aip_pkg::VALUE_W + aip_pkg::BASE_W;
  localparam int unsigned PAD_W  = aip_pkg::OUT_TDATA_W - aip_pkg::VALUE_W
                                   - aip_pkg::OFFSET_W - aip_pkg::STATUS_W;

  // -------------------------------------------------------------------------
  // Configuration register
  // -------------------------------------------------------------------------
  logic [aip_pkg::BASE_W-1:0] number_base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      number_base_q <= aip_pkg::BASE_AUTO;
    end else if (cfg_we_i) begin
      number_base_q <= cfg_wdata_i;
    end
  end

  // -------------------------------------------------------------------------
  // Input register
  // -------------------------------------------------------------------------
  logic                       in_vld_q;
  logic [aip_pkg::CHAR_W-1:0] in_char_q;
  logic                       in_first_q;
  logic                       proc;     // character in the input register is consumed
  logic                       out_vld_q;

  assign proc          = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_vld_q <= 1'b1;
    end else if (proc) begin
      in_vld_q <= 1'b0;
    end
  end

  // Payload: no reset needed
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char_q  <= s_axis_tdata;
      in_first_q <= s_axis_tuser;
    end
  end

  // -------------------------------------------------------------------------
  // Parse state
  // -------------------------------------------------------------------------
  aip_pkg::phase_e             phase_q, phase_d;
  logic [aip_pkg::VALUE_W-1:0] acc_q, acc_d;
  logic [aip_pkg::BASE_W-1:0]  base_q, base_d;
  logic                        minus_q, minus_d;
  logic                        ovf_q, ovf_d;
  logic [POS_W-1:0]            pos_q, pos_d;
  logic                        dig_q, dig_d;

  // Result of the current character
  logic                        emit;
  logic [aip_pkg::VALUE_W-1:0] res_value;
  logic [POS_W-1:0]            res_pos;
  aip_pkg::status_e            res_status;

  // Only the low CHAR_BITS of the code take part
  logic [aip_pkg::CHAR_W-1:0]  char_w;
  logic [aip_pkg::BASE_W-1:0]  digit;

  assign char_w = aip_pkg::CHAR_W'(in_char_q[CHAR_BITS-1:0]);
  assign digit  = aip_pkg::digit_of(char_w);

  always_comb begin
    logic             do_signed;
    logic             do_digit;
    logic [POS_W-1:0] pos_adv;
    logic [PROD_W-1:0] sum;
    logic             bad_base;

    // Defaults: hold
    phase_d    = phase_q;
    acc_d      = acc_q;
    base_d     = base_q;
    minus_d    = minus_q;
    ovf_d      = ovf_q;
    pos_d      = pos_q;
    dig_d      = dig_q;
    emit       = 1'b0;
    res_value  = '0;
    res_pos    = '0;
    res_status = aip_pkg::ST_OK;
    do_signed  = 1'b0;
    do_digit   = 1'b0;
    bad_base   = 1'b0;

    // A marked character restarts the parse, dropping any parse in flight
    if (in_first_q) begin
      acc_d    = '0;
      minus_d  = 1'b0;
      ovf_d    = 1'b0;
      pos_d    = '0;
      dig_d    = 1'b0;
      base_d   = number_base_q;
      bad_base = (number_base_q == aip_pkg::BASE_ONE) || (number_base_q > aip_pkg::BASE_MAX);
      phase_d  = bad_base ? aip_pkg::PH_DONE : aip_pkg::PH_BLANKS;
    end

    // At most one advance per character, so precompute it
    pos_adv = (&pos_d) ? pos_d : pos_d + 1'b1;

    if (bad_base) begin
      emit       = 1'b1;
      res_status = aip_pkg::ST_BADBASE;
    end else begin
      case (phase_d)
        aip_pkg::PH_BLANKS: begin
          if (char_w inside {aip_pkg::CH_SPACE, [aip_pkg::CH_TAB:aip_pkg::CH_CR]}) begin
            pos_d = pos_adv;
          end else if (char_w inside {aip_pkg::CH_PLUS, aip_pkg::CH_MINUS}) begin
            minus_d = (char_w == aip_pkg::CH_MINUS);
            pos_d   = pos_adv;
            phase_d = aip_pkg::PH_SIGNED;
          end else begin
            do_signed = 1'b1;
          end
        end
        aip_pkg::PH_SIGNED: begin
          do_signed = 1'b1;
        end
        aip_pkg::PH_ZERO: begin
          if (char_w inside {aip_pkg::CH_X_UP, aip_pkg::CH_X_LO}) begin
            base_d  = aip_pkg::BASE_HEX;
            pos_d   = pos_adv;
            phase_d = aip_pkg::PH_DIGITS;
          end else begin
            if (base_d == aip_pkg::BASE_AUTO) begin
              base_d = aip_pkg::BASE_OCT;
            end
            dig_d    = 1'b1;   // the leading zero is a digit
            phase_d  = aip_pkg::PH_DIGITS;
            do_digit = 1'b1;
          end
        end
        aip_pkg::PH_DIGITS: begin
          do_digit = 1'b1;
        end
        default: begin
        end
      endcase
    end

    // Sign position: a zero may open a prefix in auto or hex mode
    if (do_signed) begin
      if ((base_d == aip_pkg::BASE_AUTO || base_d == aip_pkg::BASE_HEX)
          && char_w == aip_pkg::CH_ZERO) begin
        pos_d   = pos_adv;
        phase_d = aip_pkg::PH_ZERO;
      end else begin
        if (base_d == aip_pkg::BASE_AUTO) begin
          base_d = aip_pkg::BASE_DEC;
        end
        phase_d  = aip_pkg::PH_DIGITS;
        do_digit = 1'b1;
      end
    end

    // Digit step: acc*base + d overflows exactly when it reaches 2^64
    sum = ({{aip_pkg::BASE_W{1'b0}}, acc_d} * PROD_W'(base_d)) + PROD_W'(digit);

    if (do_digit) begin
      if (char_w <= aip_pkg::ASCII_MAX && digit < base_d && base_d >= aip_pkg::BASE_MIN) begin
        if (|sum[PROD_W-1:aip_pkg::VALUE_W]) begin
          ovf_d = 1'b1;
        end else if (!ovf_d) begin
          acc_d = sum[aip_pkg::VALUE_W-1:0];
        end
        dig_d = 1'b1;
        pos_d = pos_adv;
      end else begin
        emit    = 1'b1;
        phase_d = aip_pkg::PH_DONE;
        if (!dig_d) begin
          res_status = aip_pkg::ST_NODIGITS;
        end else if (ovf_d) begin
          res_value  = '1;
          res_pos    = pos_d;
          res_status = aip_pkg::ST_OVERFLOW;
        end else begin
          res_value  = minus_d ? (~acc_d + 1'b1) : acc_d;
          res_pos    = pos_d;
          res_status = aip_pkg::ST_OK;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= aip_pkg::PH_IDLE;
      acc_q   <= '0;
      base_q  <= '0;
      minus_q <= 1'b0;
      ovf_q   <= 1'b0;
      pos_q   <= '0;
      dig_q   <= 1'b0;
    end else if (proc) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      base_q  <= base_d;
      minus_q <= minus_d;
      ovf_q   <= ovf_d;
      pos_q   <= pos_d;
      dig_q   <= dig_d;
    end
  end

  // -------------------------------------------------------------------------
  // Result register
  // -------------------------------------------------------------------------
  logic [aip_pkg::VALUE_W-1:0]  out_value_q;
  logic [aip_pkg::OFFSET_W-1:0] out_offset_q;
  aip_pkg::status_e             out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (proc && emit) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && emit) begin
      out_value_q  <= res_value;
      out_offset_q <= aip_pkg::OFFSET_W'(res_pos);
      out_status_q <= res_status;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, out_status_q, out_offset_q, out_value_q};

endmodule

`default_nettype wire

// ===== rtl/core/aip_checker.sv =====
// ---------------------------------------------------------------------------
// aip_checker: port-level checks for the ASCII integer parser
// Watches the result stream and checks handshake and result consistency.
// ---------------------------------------------------------------------------
`default_nettype none

`include "ascii_integer_parser_defines.svh"

module aip_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [aip_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [aip_pkg::VALUE_W-1:0]  value;
  logic [aip_pkg::OFFSET_W-1:0] offset;
  logic [aip_pkg::STATUS_W-1:0] status;

  assign value  = m_axis_tdata[aip_pkg::VALUE_W-1:0];
  assign offset = m_axis_tdata[aip_pkg::VALUE_W +: aip_pkg::OFFSET_W];
  assign status = m_axis_tdata[aip_pkg::VALUE_W + aip_pkg::OFFSET_W +: aip_pkg::STATUS_W];

  // Hold a stalled result
  `AIP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped or changed while stalled")

  // A parse with digits always consumed at least one character
  `AIP_ASSERT_NOW(a_offset_nonzero, clk_i, rst_ni, m_axis_tvalid && (status == aip_pkg::ST_OK || status == aip_pkg::ST_OVERFLOW), offset != '0, "digits reported with zero end offset")

  // No digits or bad base report zero value and zero offset
  `AIP_ASSERT_NOW(a_empty_result, clk_i, rst_ni, m_axis_tvalid && (status == aip_pkg::ST_NODIGITS || status == aip_pkg::ST_BADBASE), value == '0 && offset == '0, "empty result carries data")

  // Overflow saturates to all ones
  `AIP_ASSERT_NOW(a_overflow_sat, clk_i, rst_ni, m_axis_tvalid && status == aip_pkg::ST_OVERFLOW, &value, "overflow result not saturated")

endmodule

bind ascii_integer_parser aip_checker u_aip_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== dv/tb_ascii_integer_parser.sv =====
// ---------------------------------------------------------------------------
// tb_ascii_integer_parser: self-checking bench for the ASCII integer parser
// Streams character strings under a range of number bases, predicts each
// parse result in the bench and compares every result transaction with it.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_ascii_integer_parser;
  import aip_pkg::*;

  // Cycles without any transaction before the run is abandoned
  localparam int unsigned QUIET_LIMIT = 4000;
  // Quiet cycles allowed after the last result before the base is changed
  localparam int unsigned SETTLE      = 8;
  // Length of the one long receiver hold-off
  localparam int unsigned HOLD_CYCLES = 400;
  // Offset saturation point: 65535, as in the parser with its default OFFSET_BITS
  localparam logic [OFFSET_W-1:0] OFFSET_CAP = 16'hffff;
  localparam logic [VALUE_W-1:0]  ALL_ONES   = '1;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              first;
  } char_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [OFFSET_W-1:0] offset;
    status_e             status;
  } result_t;

  // DUT connections; every input starts at a known value
  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [BASE_W-1:0]      cfg_wdata_i   = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // [15:0] char_code
  logic                   s_axis_tuser  = 1'b0; // [0] first_char
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;  // [63:0] value, [79:64] offset, [81:80] status

  ascii_integer_parser dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Characters waiting to be offered, and results the parser still owes
  char_item_t char_backlog[$];
  result_t    expected_results[$];

  // Bench-side copy of the parser state
  logic [BASE_W-1:0]   cfg_base   = BASE_AUTO;
  phase_e              pstate     = PH_IDLE;
  logic [VALUE_W-1:0]  acc        = '0;
  logic [BASE_W-1:0]   radix      = '0;
  logic                negate     = 1'b0;
  logic                saturated  = 1'b0;
  logic [OFFSET_W-1:0] offset_cnt = '0;
  logic                any_digit  = 1'b0;

  // Traffic shaping: steady and hold_arm set by the sequencer at falling edges, the rest by the monitor
  bit          steady    = 1'b0;
  bit          hold_arm  = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;

  int unsigned mismatches  = 0;
  int unsigned quiet_cycles = 0;
  char_item_t  drv_item;
  result_t     drv_result;
  result_t     mon_want;

  // -------------------------------------------------------------------------
  // Predictor
  // -------------------------------------------------------------------------

  // Digit value 0..35 of a character, 36 for anything else
  function automatic logic [BASE_W-1:0] char_digit(input logic [CHAR_W-1:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return BASE_W'(c - CH_ZERO);
    if (c >= CH_A_UP && c <= CH_Z_UP) return BASE_W'(c - CH_A_UP + 10);
    if (c >= CH_A_LO && c <= CH_Z_LO) return BASE_W'(c - CH_A_LO + 10);
    return NOT_DIGIT;
  endfunction

  function automatic void bump_offset();
    if (offset_cnt < OFFSET_CAP) offset_cnt = offset_cnt + 1'b1;
  endfunction

  // Accumulate a digit, or close the number on the first character refused
  function automatic bit take_digit(input logic [CHAR_W-1:0] c, output result_t r);
    logic [BASE_W-1:0]  d;
    logic [VALUE_W-1:0] b;
    d = char_digit(c);
    b = VALUE_W'(radix);
    if (c <= ASCII_MAX && d < radix && b >= 2) begin
      if (acc > (ALL_ONES - VALUE_W'(d)) / b) saturated = 1'b1;
      else if (!saturated) acc = acc * b + VALUE_W'(d);
      any_digit = 1'b1;
      bump_offset();
      return 1'b0;
    end
    if (!any_digit) r = '{value: '0, offset: '0, status: ST_NODIGITS};
    else if (saturated) r = '{value: ALL_ONES, offset: offset_cnt, status: ST_OVERFLOW};
    else r = '{value: negate ? (VALUE_W'(0) - acc) : acc, offset: offset_cnt, status: ST_OK};
    pstate = PH_DONE;
    return 1'b1;
  endfunction

  // Character where the number proper may begin: a leading zero is held back
  // for prefix detection under the automatic and hexadecimal bases
  function automatic bit take_lead(input logic [CHAR_W-1:0] c, output result_t r);
    if ((radix == BASE_AUTO || radix == BASE_HEX) && c == CH_ZERO) begin
      bump_offset();
      pstate = PH_ZERO;
      return 1'b0;
    end
    if (radix == BASE_AUTO) radix = BASE_DEC;
    pstate = PH_DIGITS;
    return take_digit(c, r);
  endfunction

  // Advance the parser copy by one accepted character; 1 when it yields a result
  function automatic bit predict_parse(input logic [CHAR_W-1:0] c, input logic first,
                                       output result_t r);
    if (first) begin
      acc        = '0;
      negate     = 1'b0;
      saturated  = 1'b0;
      offset_cnt = '0;
      any_digit  = 1'b0;
      radix      = cfg_base;
      if (radix == BASE_ONE || radix > BASE_MAX) begin
        r = '{value: '0, offset: '0, status: ST_BADBASE};
        pstate = PH_DONE;
        return 1'b1;
      end
      pstate = PH_BLANKS;
    end
    case (pstate)
      PH_BLANKS: begin
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
          bump_offset();
          return 1'b0;
        end
        if (c == CH_PLUS || c == CH_MINUS) begin
          negate = (c == CH_MINUS);
          bump_offset();
          pstate = PH_SIGNED;
          return 1'b0;
        end
        return take_lead(c, r);
      end
      PH_SIGNED: return take_lead(c, r);
      PH_ZERO: begin
        if (c == CH_X_LO || c == CH_X_UP) begin
          radix = BASE_HEX;
          bump_offset();
          pstate = PH_DIGITS;
          return 1'b0;
        end
        if (radix == BASE_AUTO) radix = BASE_OCT;
        any_digit = 1'b1;
        pstate = PH_DIGITS;
        return take_digit(c, r);
      end
      PH_DIGITS: return take_digit(c, r);
      default: return 1'b0;
    endcase
  endfunction

  // -------------------------------------------------------------------------
  // Driver: offer characters from the backlog, idling at random. Predict
  // each character at the edge where its transaction completes.
  // -------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (predict_parse(s_axis_tdata, s_axis_tuser, drv_result))
          expected_results.push_back(drv_result);
      end
      // Hold the current character until it is taken
      if (!s_axis_tvalid || s_axis_tready) begin
        if (char_backlog.size() != 0 && (steady || $urandom_range(0, 99) >= 25)) begin
          drv_item = char_backlog.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= drv_item.code;
          s_axis_tuser  <= drv_item.first;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: check each result transaction against the oldest prediction and
  // drive tready, with one long hold-off once the sequencer arms it.
  // -------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left     <= 0;
      hold_done     <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: value %h offset %0d status %0d",
                     m_axis_tdata[63:0], m_axis_tdata[79:64], m_axis_tdata[81:80]);
        end else begin
          mon_want = expected_results.pop_front();
          if (m_axis_tdata[63:0] !== mon_want.value ||
              m_axis_tdata[79:64] !== mon_want.offset ||
              m_axis_tdata[81:80] !== mon_want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: value %h/%h offset %0d/%0d status %0d/%0d",
                       mon_want.value, m_axis_tdata[63:0], mon_want.offset,
                       m_axis_tdata[79:64], mon_want.status, m_axis_tdata[81:80]);
          end
        end
      end
      if (hold_arm && !hold_done) begin
        hold_done     <= 1'b1;
        hold_left     <= HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 25);
      end
    end
  end

  // Watchdog: abandon the run after a long spell with no transaction at all
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_ascii_integer_parser failed");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Sequencer
  // -------------------------------------------------------------------------

  task automatic push_char(input logic [CHAR_W-1:0] c, input logic first);
    char_backlog.push_back('{code: c, first: first});
  endtask

  function automatic logic [CHAR_W-1:0] digit_code(input int v, input bit upper);
    if (v < 10) return CH_ZERO + CHAR_W'(v);
    return (upper ? CH_A_UP : CH_A_LO) + CHAR_W'(v - 10);
  endfunction

  // Write the base register; only called while the parser is idle
  task automatic write_base(input logic [BASE_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_base  = v;
    @(negedge clk_i);
  endtask

  // Wait until the backlog is sent and every result is in, then let the pipeline settle
  task automatic drain();
    do @(negedge clk_i);
    while (char_backlog.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  // Queue one random string: mostly well-formed, some noise and some cut short
  task automatic gen_string(input logic [BASE_W-1:0] base);
    int  n, r, er, v;
    bit  lead, hexpre, zpre, maxrun;
    lead   = 1'b1;
    hexpre = 1'b0;
    zpre   = 1'b0;
    if ($urandom_range(0, 99) < 12) begin
      // Noise: arbitrary codes, some of them restarting the parse
      push_char(CHAR_W'($urandom_range(0, 16'hffff)), 1'b1);
      n = $urandom_range(0, 4);
      repeat (n) push_char(CHAR_W'($urandom_range(0, 16'hffff)), $urandom_range(0, 2) == 0);
      return;
    end
    n = $urandom_range(0, 3);
    repeat (n) begin
      r = $urandom_range(0, 5);
      push_char(r == 0 ? CH_SPACE : CHAR_W'(8 + r), lead);
      lead = 1'b0;
    end
    r = $urandom_range(0, 3);
    if (r == 1 || r == 2) begin
      push_char(r == 1 ? CH_PLUS : CH_MINUS, lead);
      lead = 1'b0;
    end
    r = $urandom_range(0, 9);
    if ((base == BASE_AUTO || base == BASE_HEX) ? r < 3 : r == 9) begin
      push_char(CH_ZERO, lead);
      push_char($urandom_range(0, 1) ? CH_X_UP : CH_X_LO, 1'b0);
      lead   = 1'b0;
      hexpre = 1'b1;
    end else if (base == BASE_AUTO && r < 6) begin
      push_char(CH_ZERO, lead);
      lead = 1'b0;
      zpre = 1'b1;
    end
    // Radix the digits are drawn from
    if (base == BASE_AUTO) er = hexpre ? 16 : (zpre ? 8 : 10);
    else if (base >= BASE_MIN && base <= BASE_MAX) er = base;
    else er = 10;
    r = $urandom_range(0, 99);
    if (r < 5) n = 0;
    else if (r < 20) n = (er <= 4) ? $urandom_range(30, 70) : $urandom_range(12, 24);
    else n = $urandom_range(1, 8);
    maxrun = ($urandom_range(0, 19) == 0);
    repeat (n) begin
      v = maxrun ? er - 1 : $urandom_range(0, er - 1);
      if (!maxrun && er < 36 && $urandom_range(0, 29) == 0) v = $urandom_range(er, 35);
      push_char(digit_code(v, $urandom_range(0, 1)), lead);
      lead = 1'b0;
    end
    // Drop the terminator now and then: the next string restarts the parse
    if ($urandom_range(0, 9) == 0) return;
    case ($urandom_range(0, 5))
      0: push_char(16'h003b, lead);
      1: push_char(CH_SPACE, lead);
      2: push_char(16'h0000, lead);
      3: push_char(16'hffff, lead);
      4: push_char(CHAR_W'($urandom_range(16'h0080, 16'hffff)), lead);
      default: push_char(CHAR_W'($urandom_range(0, 127)), lead);
    endcase
    n = $urandom_range(0, 2);
    repeat (n) push_char(CHAR_W'($urandom_range(0, 16'hffff)), 1'b0);
  endtask

  // One configuration phase of random strings
  task automatic run_phase(input logic [BASE_W-1:0] base, input int count,
                           input bit calm, input bit arm);
    int start;
    write_base(base);
    start = char_backlog.size();
    while (char_backlog.size() - start < count) gen_string(base);
    // Close any parse still open before the base changes again
    push_char(16'h003b, 1'b0);
    steady   = calm;
    hold_arm = arm;
    drain();
    steady = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed strings under the reset base (automatic detection)
    // blanks, plus sign, decimal: " \t+12;"
    push_char(CH_SPACE, 1'b1); push_char(CH_TAB, 1'b0); push_char(CH_PLUS, 1'b0);
    push_char(16'h0031, 1'b0); push_char(16'h0032, 1'b0); push_char(16'h003b, 1'b0);
    // minus sign with hexadecimal prefix: "-0x1f!"
    push_char(CH_MINUS, 1'b1); push_char(CH_ZERO, 1'b0); push_char(CH_X_LO, 1'b0);
    push_char(16'h0031, 1'b0); push_char(16'h0066, 1'b0); push_char(16'h0021, 1'b0);
    // bare prefix with no hex digit after it
    push_char(CH_ZERO, 1'b1); push_char(CH_X_UP, 1'b0); push_char(CH_Z_UP, 1'b0);
    // octal, ended by a wide code
    push_char(CH_ZERO, 1'b1); push_char(16'h0037, 1'b0); push_char(16'hffff, 1'b0);
    // restart in mid-parse, then unmarked characters after the result
    push_char(16'h0035, 1'b1); push_char(CH_NINE, 1'b1); push_char(CH_CR, 1'b0);
    push_char(CH_A_LO, 1'b0); push_char(16'h0033, 1'b0);
    // no digits at all, and the extreme codes
    push_char(16'h0071, 1'b1); push_char(16'h0000, 1'b0);
    push_char(16'h0000, 1'b1);
    push_char(16'hffff, 1'b1);
    drain();

    // Bad base: one result at the first character, the rest ignored
    write_base(BASE_ONE);
    push_char(16'h0037, 1'b1); push_char(16'h0033, 1'b0);
    drain();

    // Long run of zeros: the offset climbs while the value stays zero
    write_base(BASE_DEC);
    push_char(CH_ZERO, 1'b1);
    repeat (40) push_char(CH_ZERO, 1'b0);
    push_char(16'h003b, 1'b0);
    drain();

    // Random phases across the base range; one with the long receiver
    // hold-off and one with no idling on either side
    run_phase(BASE_AUTO, 200, 1'b0, 1'b0);
    run_phase(BASE_MIN,  200, 1'b0, 1'b1);
    run_phase(BASE_OCT,  200, 1'b0, 1'b0);
    run_phase(BASE_DEC,  200, 1'b1, 1'b0);
    run_phase(BASE_HEX,  200, 1'b0, 1'b0);
    run_phase(BASE_MAX,  200, 1'b0, 1'b0);
    run_phase(6'd63,      40, 1'b0, 1'b0);
    run_phase(6'd37,      30, 1'b0, 1'b0);
    run_phase(BASE_ONE,   30, 1'b0, 1'b0);
    run_phase(BASE_W'($urandom_range(2, 36)), 200, 1'b0, 1'b0);
    run_phase(BASE_W'($urandom_range(0, 63)), 100, 1'b0, 1'b0);
    run_phase(BASE_AUTO,  60, 1'b0, 1'b0);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb_ascii_integer_parser passed");
    end else begin
      $display("tb_ascii_integer_parser failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/aip_pkg.sv
rtl/core/ascii_integer_parser.sv
rtl/core/aip_checker.sv
dv/tb_ascii_integer_parser.sv
